/* rtl/trmm_pkg.sv */
package trmm_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned StepW = 6;

  // Steps that do plain register moves, adds and XORs instead of a multiply.
  localparam logic [StepW-1:0] STEP_A_JOIN = 6'd6;
  localparam logic [StepW-1:0] STEP_A_DONE = 6'd13;
  localparam logic [StepW-1:0] STEP_B_JOIN = 6'd23;
  localparam logic [StepW-1:0] STEP_B_DONE = 6'd33;

  // Configuration register indexes.
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  localparam logic [WordW-1:0] KEY_A1_OFFSET = 32'h69FB0000;
  localparam logic [WordW-1:0] KEY_A2_OFFSET = 32'h13DB0000;

  typedef enum logic [1:0] {
    KEY_A1,
    KEY_A2,
    KEY_B1,
    KEY_B2
  } key_sel_t;

  // One micro-operation of the shared multiply-add unit.
  typedef struct packed {
    logic             misc;
    logic             use_key;
    key_sel_t         key;
    logic [WordW-1:0] coef;
    logic             use_high;
    logic             neg;
    logic             add_p;
    logic             to_v;
  } uop_t;

  typedef struct packed {
    logic [WordW-1:0] op_a;
    logic [WordW-1:0] op_b;
    logic [WordW-1:0] base;
    logic             neg;
  } mac_req_t;

  function automatic uop_t op_misc();
    uop_t u;
    u = '0;
    u.misc = 1'b1;
    return u;
  endfunction

  // p = +/- coef * v
  function automatic uop_t op_mul_p(input logic [WordW-1:0] coef, input logic neg);
    uop_t u;
    u = '0;
    u.coef = coef;
    u.neg  = neg;
    return u;
  endfunction

  // v = p +/- coef * (v >> 16)
  function automatic uop_t op_mix_v(input logic [WordW-1:0] coef, input logic neg);
    uop_t u;
    u = '0;
    u.coef     = coef;
    u.neg      = neg;
    u.use_high = 1'b1;
    u.add_p    = 1'b1;
    u.to_v     = 1'b1;
    return u;
  endfunction

  // p = key * v, or v = key * v when to_v is set
  function automatic uop_t op_key(input key_sel_t key, input logic to_v);
    uop_t u;
    u = '0;
    u.use_key = 1'b1;
    u.key     = key;
    u.to_v    = to_v;
    return u;
  endfunction

  function automatic uop_t uop_rom(input logic [StepW-1:0] step);
    uop_t u;
    unique case (step)
      6'd0:  u = op_key(KEY_A1, 1'b0);
      6'd1:  u = op_mix_v(32'h10FA9605, 1'b1);
      6'd2:  u = op_mul_p(32'h79F8A395, 1'b0);
      6'd3:  u = op_mix_v(32'h689B6B9F, 1'b0);
      6'd4:  u = op_mul_p(32'hEA970001, 1'b0);
      6'd5:  u = op_mix_v(32'h3C101569, 1'b1);
      6'd7:  u = op_key(KEY_A2, 1'b0);
      6'd8:  u = op_mix_v(32'h3CE8EC25, 1'b1);
      6'd9:  u = op_mul_p(32'h59C3AF2D, 1'b0);
      6'd10: u = op_mix_v(32'h2232E0F1, 1'b1);
      6'd11: u = op_mul_p(32'h1EC90001, 1'b0);
      6'd12: u = op_mix_v(32'h35BD1EC9, 1'b0);
      6'd14: u = op_key(KEY_B1, 1'b1);
      6'd15: u = op_mul_p(32'hB1110000, 1'b0);
      6'd16: u = op_mix_v(32'h30674EEF, 1'b1);
      6'd17: u = op_mul_p(32'h5B9F0000, 1'b0);
      6'd18: u = op_mix_v(32'h78F7A461, 1'b1);
      6'd19: u = op_mul_p(32'h46930000, 1'b1);
      6'd20: u = op_mix_v(32'h12CEB96D, 1'b0);
      6'd21: u = op_mul_p(32'h1D830000, 1'b0);
      6'd22: u = op_mix_v(32'h257E1D83, 1'b0);
      6'd24: u = op_key(KEY_B2, 1'b1);
      6'd25: u = op_mul_p(32'h16F50000, 1'b0);
      6'd26: u = op_mix_v(32'h5D8BE90B, 1'b1);
      6'd27: u = op_mul_p(32'h96FF0000, 1'b0);
      6'd28: u = op_mix_v(32'h2C7C6901, 1'b1);
      6'd29: u = op_mul_p(32'h2B890000, 1'b0);
      6'd30: u = op_mix_v(32'h7C932B89, 1'b0);
      6'd31: u = op_mul_p(32'h9F690000, 1'b0);
      6'd32: u = op_mix_v(32'h405B6097, 1'b1);
      default: u = op_misc();
    endcase
    return u;
  endfunction

endpackage

/* rtl/trmm_mac.sv */
module trmm_mac
  import trmm_pkg::*;
(
  input  mac_req_t         req,
  output logic [WordW-1:0] result
);

  logic [WordW-1:0] prod;

  // Only the low word of the product matters: everything is modulo 2^32.
  assign prod   = req.op_a * req.op_b;
  assign result = req.neg ? (req.base - prod) : (req.base + prod);

endmodule

/* rtl/two_round_multiply_mix_hash.sv */
// A chunk is taken only in idle; no new chunk is accepted until the last one has run its
// 34 micro-steps through the single shared 32x32 multiply-add unit, which does every
// multiply of both rounds; the final chunk's hash then appears on the out_ channel.
// Reset (rst_n low, synchronous) clears both rounds' state, drops out_valid, returns the
// sequencer to idle and sets all four key registers as a write of zero would.
module two_round_multiply_mix_hash
  import trmm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WordW-1:0] in_chunk_low,
  input  logic [WordW-1:0] in_chunk_high,
  input  logic             in_final_chunk,

  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_hash_low,
  output logic [WordW-1:0] out_hash_high,

  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [WordW-1:0] cfg_data
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;

  // Keys are kept in the form the rounds consume: ORed with one, and for round A
  // also offset, so no adder sits in front of the multiplier.
  logic [WordW-1:0] key_a1_r, key_a2_r, key_b1_r, key_b2_r;

  // Round state.
  logic [WordW-1:0] ra_acc_r, ra_acc_nxt;
  logic [WordW-1:0] ra_car_r, ra_car_nxt;
  logic [WordW-1:0] rb_acc_r, rb_acc_nxt;
  logic [WordW-1:0] rb_car_r, rb_car_nxt;

  // Working registers: v is the value being mixed, p the partial product, t and z
  // the side terms that feed the carry words.
  logic [WordW-1:0] v_r, v_nxt;
  logic [WordW-1:0] p_r, p_nxt;
  logic [WordW-1:0] t_r, t_nxt;
  logic [WordW-1:0] z_r, z_nxt;

  // The chunk held for the duration of its transaction's processing.
  logic [WordW-1:0] lo_r, lo_nxt;
  logic [WordW-1:0] hi_r, hi_nxt;
  logic             last_r, last_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_low_r, out_low_nxt;
  logic [WordW-1:0] out_high_r, out_high_nxt;

  uop_t             uop;
  mac_req_t         mac_req;
  logic [WordW-1:0] mac_res;
  logic [WordW-1:0] key_val;
  logic [WordW-1:0] car_b;
  logic [WordW-1:0] cfg_key;

  assign uop = uop_rom(step_r);

  always_comb begin
    unique case (uop.key)
      KEY_A1:  key_val = key_a1_r;
      KEY_A2:  key_val = key_a2_r;
      KEY_B1:  key_val = key_b1_r;
      default: key_val = key_b2_r;
    endcase
  end

  // Operand selection for the shared unit: a constant or key times either the
  // working value or its upper half, added to or subtracted from p or zero.
  assign mac_req.op_a = uop.use_key ? key_val : uop.coef;
  assign mac_req.op_b = uop.use_high ? {{(WordW/2){1'b0}}, v_r[WordW-1:WordW/2]} : v_r;
  assign mac_req.base = uop.add_p ? p_r : '0;
  assign mac_req.neg  = uop.neg;

  trmm_mac u_mac (
    .req    (mac_req),
    .result (mac_res)
  );

  // Round B's new carry: old carry plus its saved z term plus the new accumulator.
  assign car_b   = rb_car_r + z_r + v_r;
  assign cfg_key = cfg_data | {{(WordW-1){1'b0}}, 1'b1};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ra_acc_nxt    = ra_acc_r;
    ra_car_nxt    = ra_car_r;
    rb_acc_nxt    = rb_acc_r;
    rb_car_nxt    = rb_car_r;
    v_nxt         = v_r;
    p_nxt         = p_r;
    t_nxt         = t_r;
    z_nxt         = z_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_low_nxt   = out_low_r;
    out_high_nxt  = out_high_r;

    // A waiting hash leaves when the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lo_nxt    = in_chunk_low;
          hi_nxt    = in_chunk_high;
          last_nxt  = in_final_chunk;
          v_nxt     = in_chunk_low + ra_acc_r;
          step_nxt  = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 1'b1;
        if (!uop.misc) begin
          if (uop.to_v) begin
            v_nxt = mac_res;
          end else begin
            p_nxt = mac_res;
          end
        end else begin
          unique case (step_r)
            STEP_A_JOIN: begin
              // v holds round A's z: fold in the high word and start the carry term.
              v_nxt = v_r + hi_r;
              t_nxt = ra_car_r + v_r;
            end
            STEP_A_DONE: begin
              ra_acc_nxt = v_r;
              ra_car_nxt = t_r + v_r;
              v_nxt      = lo_r + rb_acc_r;
            end
            STEP_B_JOIN: begin
              z_nxt = v_r;
              v_nxt = v_r + hi_r;
            end
            STEP_B_DONE: begin
              if (!last_r) begin
                rb_acc_nxt = v_r;
                rb_car_nxt = car_b;
                state_nxt  = S_IDLE;
              end else if (!out_valid_r || out_ready) begin
                // Final chunk: publish the hash and start the next message clean.
                out_valid_nxt = 1'b1;
                out_low_nxt   = ra_acc_r ^ v_r;
                out_high_nxt  = ra_car_r ^ car_b;
                ra_acc_nxt    = '0;
                ra_car_nxt    = '0;
                rb_acc_nxt    = '0;
                rb_car_nxt    = '0;
                state_nxt     = S_IDLE;
              end else begin
                // The previous hash has not been taken yet: hold this step.
                step_nxt = step_r;
              end
            end
            default: begin
              step_nxt = step_r + 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      ra_acc_r    <= '0;
      ra_car_r    <= '0;
      rb_acc_r    <= '0;
      rb_car_r    <= '0;
      out_valid_r <= 1'b0;
      key_a1_r    <= KEY_A1_OFFSET + 32'd1;
      key_a2_r    <= KEY_A2_OFFSET + 32'd1;
      key_b1_r    <= 32'd1;
      key_b2_r    <= 32'd1;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      ra_acc_r    <= ra_acc_nxt;
      ra_car_r    <= ra_car_nxt;
      rb_acc_r    <= rb_acc_nxt;
      rb_car_r    <= rb_car_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_LOW: begin
            key_a1_r <= cfg_key + KEY_A1_OFFSET;
            key_b1_r <= cfg_key;
          end
          default: begin
            key_a2_r <= cfg_key + KEY_A2_OFFSET;
            key_b2_r <= cfg_key;
          end
        endcase
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    p_r        <= p_nxt;
    t_r        <= t_nxt;
    z_r        <= z_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    last_r     <= last_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_hash_low  = out_low_r;
  assign out_hash_high = out_high_r;

endmodule
